// ===== sv/vdc_pkg.sv =====
package vdc_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned PROD_W       = 32;
  localparam int unsigned COLSUM_W     = 34;
  localparam int unsigned SUM_W        = 35;
  localparam int unsigned ROW_W        = 16;
  localparam int unsigned OUT_COL_W    = 10;
  localparam int unsigned CFG_COLS_W   = 11;
  localparam int unsigned KERNEL_REG_W = 48;
  localparam int unsigned KERNEL_REGS  = 3;
  localparam int unsigned CFG_DATA_W   = 48;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned LINES        = 2;

  // Parameter defaults
  localparam int unsigned KERNEL_ROWS_DEF = 3;
  localparam int unsigned KERNEL_COLS_DEF = 3;
  localparam int unsigned MAX_COLUMNS_DEF = 1024;

  // Image size limits and reset values
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned COLS_RESET = 1024;
  localparam int unsigned ROWS_RESET = 1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_COLUMNS = 3'd0,
    CFG_IMAGE_ROWS    = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Per-cycle control of the window cells
  typedef struct packed {
    logic shift;    // take in a new window column
    logic advance;  // move products and column sums one stage on
  } cell_ctrl_t;

  // Position and frame mark that travel with a result
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } res_meta_t;

endpackage

// ===== sv/valid_2d_correlation_stream.sv =====
// Streaming valid-region 3x3 cross-correlation (kernel not flipped). Samples enter in raster
// order, one per clock when neither side stalls; each sample whose window lies fully inside
// the image produces one 35-bit sum with its row and column in the valid region, and the last
// result of the frame carries frame_last. Results go through res1 to res4 and the output
// register. The rate of one sample per cycle is set by the single read and single write a cycle
// of the line memory (both previous rows packed side by side in one entry, MAX_COLUMNS deep) and
// by the window cells shifting one column per sample. The output register stalls the input only
// when it holds an untaken result and a result is waiting behind it. Line memory contents are
// undefined after reset and need no clearing: a result only reads entries written earlier in the
// same frame. Write size and kernel registers only while idle; the block does not enforce it.
// A size change takes effect at once, and counters past the new end wrap after the next sample.
module valid_2d_correlation_stream #(
  parameter int unsigned KERNEL_ROWS = vdc_pkg::KERNEL_ROWS_DEF,
  parameter int unsigned KERNEL_COLS = vdc_pkg::KERNEL_COLS_DEF,
  parameter int unsigned MAX_COLUMNS = vdc_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [vdc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [vdc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [vdc_pkg::SAMPLE_W-1:0] sample_i,
  // result requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vdc_pkg::SUM_W-1:0]    sum_o,
  output logic [vdc_pkg::ROW_W-1:0]           out_row_o,
  output logic [vdc_pkg::OUT_COL_W-1:0]       out_column_o,
  output logic                                frame_last_o
);
  import vdc_pkg::*;

  localparam int unsigned CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CMPW   = (CFG_COLS_W > CW + 1) ? CFG_COLS_W : CW + 1;
  localparam int unsigned XW     = (CW > OUT_COL_W) ? CW : OUT_COL_W;
  localparam int unsigned LINE_W = LINES * SAMPLE_W;

  // Configuration registers
  logic [CFG_COLS_W-1:0]   cols_q;
  logic [ROW_W-1:0]        rows_q;
  logic [KERNEL_REG_W-1:0] kernel_q [KERNEL_REGS];

  // Position counters
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Pipeline
  logic             adv, load_out, accept;
  logic             v1_q, res1_q, res2_q, res3_q, res4_q;
  sample_t          s1_q;
  logic [CW-1:0]    c1_q;
  res_meta_t        meta1_q, meta2_q, meta3_q, meta4_q;
  res_meta_t        meta_d;

  logic [CMPW-1:0]  cols_x, cols_used;
  logic [ROW_W-1:0] rows_used;
  logic             last_col, last_row, produce;
  logic [XW-1:0]    col_x;

  logic [LINE_W-1:0] rd_line;
  sample_t [2:0]     col3;
  cell_ctrl_t        cell_ctrl;

  sample_t [KERNEL_ROWS-1:0]  new_col;
  sample_t [KERNEL_ROWS-1:0]  win_col [KERNEL_COLS];
  sample_t [KERNEL_ROWS-1:0]  coef    [KERNEL_COLS];
  logic signed [COLSUM_W-1:0] colsum  [KERNEL_COLS];
  logic signed [SUM_W-1:0]    total;

  logic                       out_valid_q;
  logic signed [SUM_W-1:0]    sum_q;
  res_meta_t                  meta_out_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_COLS_W'(COLS_RESET);
      rows_q <= ROW_W'(ROWS_RESET);
      for (int i = 0; i < KERNEL_REGS; i++) begin
        kernel_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_COLUMNS: cols_q      <= cfg_data_i[CFG_COLS_W-1:0];
        CFG_IMAGE_ROWS:    rows_q      <= cfg_data_i[ROW_W-1:0];
        CFG_KERNEL_TOP:    kernel_q[0] <= cfg_data_i[KERNEL_REG_W-1:0];
        CFG_KERNEL_MIDDLE: kernel_q[1] <= cfg_data_i[KERNEL_REG_W-1:0];
        CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg_data_i[KERNEL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp image size to the supported range
  always_comb begin
    cols_x = CMPW'(cols_q);
    if (cols_x < CMPW'(MIN_DIM)) begin
      cols_used = CMPW'(MIN_DIM);
    end else if (cols_x > CMPW'(MAX_COLUMNS)) begin
      cols_used = CMPW'(MAX_COLUMNS);
    end else begin
      cols_used = cols_x;
    end
    rows_used = (rows_q < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : rows_q;
  end

  // Decide end of row and frame, warm-up and result position
  always_comb begin
    last_col = (CMPW'(col_q) + CMPW'(1)) >= cols_used;
    last_row = ({1'b0, row_q} + (ROW_W + 1)'(1)) >= {1'b0, rows_used};
    produce  = (row_q >= ROW_W'(KERNEL_ROWS - 1)) && (col_q >= CW'(KERNEL_COLS - 1));
    col_x    = XW'(col_q) - XW'(KERNEL_COLS - 1);
    meta_d.row  = row_q - ROW_W'(KERNEL_ROWS - 1);
    meta_d.col  = col_x[OUT_COL_W-1:0];
    meta_d.last = last_col && last_row;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
  end

  // Advance all stages unless a result would overwrite a stalled one
  assign load_out   = !out_valid_q || !out_stall_i;
  assign adv        = !res4_q || load_out;
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;

  // Step position counters per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Hold stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      res1_q <= 1'b0;
      res2_q <= 1'b0;
      res3_q <= 1'b0;
      res4_q <= 1'b0;
    end else if (adv) begin
      v1_q   <= accept;
      res1_q <= accept && produce;
      res2_q <= res1_q;
      res3_q <= res2_q;
      res4_q <= res3_q;
    end
  end

  // Carry sample, address and result position down the pipeline
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q    <= sample_i;
      c1_q    <= col_q;
      meta1_q <= meta_d;
    end
    if (adv) begin
      meta2_q <= meta1_q;
      meta3_q <= meta2_q;
      meta4_q <= meta3_q;
    end
  end

  // Line memory: entry holds {row above previous, previous row}
  vdc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (adv && v1_q),
    .wr_addr_i (c1_q),
    .wr_data_i ({rd_line[SAMPLE_W-1:0], s1_q}),
    .re_i      (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_line)
  );

  // Newest window column, oldest row first
  assign col3[0] = rd_line[LINE_W-1:SAMPLE_W];
  assign col3[1] = rd_line[SAMPLE_W-1:0];
  assign col3[2] = s1_q;

  assign cell_ctrl.shift   = adv && v1_q;
  assign cell_ctrl.advance = adv;

  // Chain of window cells, newest column enters at the far end
  for (genvar k = 0; k < KERNEL_ROWS; k++) begin : g_new_col
    assign new_col[k] = col3[3 - KERNEL_ROWS + k];
  end

  for (genvar l = 0; l < KERNEL_COLS; l++) begin : g_cell
    for (genvar k = 0; k < KERNEL_ROWS; k++) begin : g_coef
      assign coef[l][k] = kernel_q[k][COEF_W*l +: COEF_W];
    end

    if (l == KERNEL_COLS - 1) begin : g_head
      vdc_cell #(
        .KR (KERNEL_ROWS)
      ) u_cell (
        .clk_i    (clk_i),
        .ctrl_i   (cell_ctrl),
        .col_i    (new_col),
        .coef_i   (coef[l]),
        .col_o    (win_col[l]),
        .colsum_o (colsum[l])
      );
    end else begin : g_body
      vdc_cell #(
        .KR (KERNEL_ROWS)
      ) u_cell (
        .clk_i    (clk_i),
        .ctrl_i   (cell_ctrl),
        .col_i    (win_col[l+1]),
        .coef_i   (coef[l]),
        .col_o    (win_col[l]),
        .colsum_o (colsum[l])
      );
    end
  end

  // Add the column sums of all cells
  always_comb begin
    total = '0;
    for (int l = 0; l < KERNEL_COLS; l++) begin
      total = total + SUM_W'(colsum[l]);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= res4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sum_q      <= total;
      meta_out_q <= meta4_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sum_o        = sum_q;
  assign out_row_o    = meta_out_q.row;
  assign out_column_o = meta_out_q.col;
  assign frame_last_o = meta_out_q.last;

  // Line memory is never read and written at one address in a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && adv && v1_q) |-> (col_q != c1_q))
    else $error("line memory read and write collide");

  // A result flag only travels with an accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res1_q |-> v1_q)
    else $error("result flag without sample");

  // A waiting result behind a stalled output blocks new samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && res4_q) |-> in_stall_o)
    else $error("pipeline advanced over a stalled result");

  // A pending result stays in the last stage while the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && res4_q) |=> res4_q)
    else $error("pending result dropped");

endmodule

// ===== sv/vdc_ram.sv =====
module vdc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/vdc_cell.sv =====
module vdc_cell #(
  parameter int unsigned KR = vdc_pkg::KERNEL_ROWS_DEF
) (
  input  logic                                 clk_i,
  input  vdc_pkg::cell_ctrl_t                  ctrl_i,
  input  vdc_pkg::sample_t [KR-1:0]            col_i,
  input  vdc_pkg::sample_t [KR-1:0]            coef_i,
  output vdc_pkg::sample_t [KR-1:0]            col_o,
  output logic signed [vdc_pkg::COLSUM_W-1:0]  colsum_o
);
  import vdc_pkg::*;

  sample_t [KR-1:0]           win_q;
  logic signed [PROD_W-1:0]   prod_q [KR];
  logic signed [COLSUM_W-1:0] colsum_d;
  logic signed [COLSUM_W-1:0] colsum_q;

  // Shift the window column in from the input (neighbor cell or new column)
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      win_q <= col_i;
    end
  end

  // Multiply each sample of the column by its coefficient and register the column sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      for (int k = 0; k < KR; k++) begin
        prod_q[k] <= PROD_W'($signed(win_q[k])) * PROD_W'($signed(coef_i[k]));
      end
      colsum_q <= colsum_d;
    end
  end

  // Add the column's products
  always_comb begin
    colsum_d = '0;
    for (int k = 0; k < KR; k++) begin
      colsum_d = colsum_d + COLSUM_W'(prod_q[k]);
    end
  end

  assign col_o    = win_q;
  assign colsum_o = colsum_q;

endmodule
